>>> rtl/gbdf_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbdf_pkg
// Shared types, codes and constants of the grid distance field block.
// ----------------------------------------------------------------------------
package gbdf_pkg;

    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 8;

    localparam logic [7:0] RADIUS_RESET   = 8'd25;
    localparam logic [6:0] MAP_SIZE_RESET = 7'd64;
    localparam logic [7:0] UNREACHED      = 8'hff;

    typedef enum logic [1:0] {
        OP_WRITE_WALL = 2'd0,
        OP_COMPUTE    = 2'd1,
        OP_READ       = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        REG_SINK_RADIUS = 2'd0,
        REG_MAP_WIDTH   = 2'd1,
        REG_MAP_HEIGHT  = 2'd2
    } cfg_reg_t;

    typedef enum logic [3:0] {
        ST_BOOT,
        ST_IDLE,
        ST_CLEAR,
        ST_SEED,
        ST_POP,
        ST_HERE,
        ST_VALUE,
        ST_NEIGHBOR,
        ST_DONE
    } gbdf_state_t;

    typedef struct packed {
        logic [1:0] operation;
        logic [5:0] cell_x;
        logic [5:0] cell_y;
        logic       wall_bit;
    } req_item_t;

    typedef struct packed {
        logic [7:0] distance;
        logic       cell_is_wall;
    } rsp_item_t;

    // neighbor steps, two's complement: 2'b11 is -1
    function automatic logic [1:0] step_dx(input logic [2:0] k);
        logic [1:0] d;
        case (k)
            3'd0:    d = 2'b11;
            3'd1:    d = 2'b01;
            3'd2:    d = 2'b00;
            3'd3:    d = 2'b00;
            3'd4:    d = 2'b11;
            3'd5:    d = 2'b01;
            3'd6:    d = 2'b01;
            default: d = 2'b11;
        endcase
        return d;
    endfunction

    function automatic logic [1:0] step_dy(input logic [2:0] k);
        logic [1:0] d;
        case (k)
            3'd0:    d = 2'b00;
            3'd1:    d = 2'b00;
            3'd2:    d = 2'b11;
            3'd3:    d = 2'b01;
            3'd4:    d = 2'b11;
            3'd5:    d = 2'b11;
            3'd6:    d = 2'b01;
            default: d = 2'b01;
        endcase
        return d;
    endfunction

endpackage
`default_nettype wire

>>> rtl/grid_bfs_distance_field_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// grid_bfs_distance_field_core
// Wall bitmap and 8-neighbor breadth-first distance map over a 2D grid.
// ----------------------------------------------------------------------------
//  channel  direction  handshake                 payload
//  req      in         req_valid / req_ready     req_item_t
//  rsp      out        rsp_valid / rsp_ready     rsp_item_t
//  cfg      in         cfg_we (no wait)          cfg_index, cfg_data
//
//  write and read items: one memory access each, result in the cycle after
//  the accept; req_ready keeps room for that result, and a new item can be
//  taken while that result is still pending if the buffer is empty.
//  compute item: a sweep clears the distance map and a seed step writes the
//  source; each dequeued cell is popped and read, and each cell that spreads
//  then reads and checks its 8 neighbors (one memory read port); a final pop
//  finds the queue empty and the result is handed over.
//  after reset a sweep over all 2^AW entries (4096 at 64 x 64) fills both
//  maps; req_ready stays low meanwhile.
//  a stalled rsp holds results in the buffer; req stalls once it is full.
// ----------------------------------------------------------------------------
module grid_bfs_distance_field_core
    import gbdf_pkg::*;
#(
    parameter int MAX_WIDTH  = DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = DEF_MAX_HEIGHT
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    output logic                        req_ready,
    input  wire req_item_t              req,
    output logic                        rsp_valid,
    input  wire logic                   rsp_ready,
    output rsp_item_t                   rsp,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int XW  = $clog2(MAX_WIDTH);
    localparam int YW  = $clog2(MAX_HEIGHT);
    localparam int AW  = XW + YW;
    localparam int CW0 = ((XW > YW) ? XW : YW) + 1;
    localparam int CW  = (CW0 > 7) ? CW0 : 7;
    localparam logic [CW-1:0] XLIM = CW'(MAX_WIDTH);
    localparam logic [CW-1:0] YLIM = CW'(MAX_HEIGHT);

    gbdf_state_t   state_reg;
    gbdf_state_t   state_next;

    logic [7:0]    sink_radius_reg;
    logic [6:0]    map_width_reg;
    logic [6:0]    map_height_reg;

    logic          pend_reg;
    logic [1:0]    pend_op_reg;
    logic          pend_in_reg;
    logic          pend_wb_reg;
    logic          held_wall_reg;
    logic [AW-1:0] src_addr_reg;
    logic          src_in_reg;

    logic [AW-1:0] sweep_reg;
    logic [AW-1:0] sweep_next;
    logic [AW-1:0] here_reg;
    logic [AW-1:0] here_next;
    logic [7:0]    value_reg;
    logic [7:0]    value_next;
    logic [2:0]    k_reg;
    logic [2:0]    k_next;
    logic [AW-1:0] nb_addr_reg;
    logic [AW-1:0] nb_addr_next;
    logic          nb_in_reg;
    logic          nb_in_next;

    logic          wall_we;
    logic          dist_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    logic          wall_wdata;
    logic [7:0]    dist_wdata;
    logic          wall_q;
    logic [7:0]    dist_q;

    logic          q_clear;
    logic          q_push;
    logic [AW-1:0] q_push_data;
    logic          q_pop;
    logic [AW-1:0] q_head;
    logic          q_empty;

    logic          ob_push;
    rsp_item_t     ob_item;
    logic [1:0]    ob_level;

    logic          req_fire;
    logic [CW-1:0] req_x;
    logic [CW-1:0] req_y;
    logic          req_in;
    logic [AW-1:0] req_addr;

    logic [CW-1:0] hx;
    logic [CW-1:0] hy;
    logic [2:0]    nb_k;
    logic [1:0]    dx;
    logic [1:0]    dy;
    logic [CW-1:0] nx;
    logic [CW-1:0] ny;
    logic          nb_in_calc;
    logic [AW-1:0] nb_addr_calc;
    logic          grow;

    assign req_ready = (state_reg == ST_IDLE)
                    && ((ob_level == 2'd0) || ((ob_level == 2'd1) && !pend_reg));
    assign req_fire  = req_valid && req_ready;

    assign req_x    = CW'(req.cell_x);
    assign req_y    = CW'(req.cell_y);
    assign req_in   = (req_x < CW'(map_width_reg)) && (req_x < XLIM)
                   && (req_y < CW'(map_height_reg)) && (req_y < YLIM);
    assign req_addr = {req_y[YW-1:0], req_x[XW-1:0]};

    // neighbor of the current cell; a step off the low edge wraps to all ones
    assign hx   = CW'(here_reg[XW-1:0]);
    assign hy   = CW'(here_reg[AW-1:XW]);
    assign nb_k = (state_reg == ST_NEIGHBOR) ? (k_reg + 3'd1) : 3'd0;
    assign dx   = step_dx(nb_k);
    assign dy   = step_dy(nb_k);
    assign nx   = hx + {{(CW-2){dx[1]}}, dx};
    assign ny   = hy + {{(CW-2){dy[1]}}, dy};
    assign nb_in_calc   = (nx < CW'(map_width_reg)) && (nx < XLIM)
                       && (ny < CW'(map_height_reg)) && (ny < YLIM);
    assign nb_addr_calc = {ny[YW-1:0], nx[XW-1:0]};

    assign grow = nb_in_reg && !wall_q
               && ({1'b0, dist_q} > ({1'b0, value_reg} + 9'd1));

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sink_radius_reg <= RADIUS_RESET;
            map_width_reg   <= MAP_SIZE_RESET;
            map_height_reg  <= MAP_SIZE_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_SINK_RADIUS: sink_radius_reg <= cfg_data;
                REG_MAP_WIDTH:   map_width_reg   <= cfg_data[6:0];
                REG_MAP_HEIGHT:  map_height_reg  <= cfg_data[6:0];
                default: ;
            endcase
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_BOOT:
            begin
                if (&sweep_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req_fire && (req.operation == OP_COMPUTE))
                begin
                    state_next = ST_CLEAR;
                end
            end
            ST_CLEAR:
            begin
                if (&sweep_reg)
                begin
                    state_next = ST_SEED;
                end
            end
            ST_SEED:
            begin
                state_next = ST_POP;
            end
            ST_POP:
            begin
                state_next = q_empty ? ST_DONE : ST_HERE;
            end
            ST_HERE:
            begin
                state_next = ST_VALUE;
            end
            ST_VALUE:
            begin
                state_next = (dist_q >= sink_radius_reg) ? ST_POP : ST_NEIGHBOR;
            end
            ST_NEIGHBOR:
            begin
                if (k_reg == 3'd7)
                begin
                    state_next = ST_POP;
                end
            end
            ST_DONE:
            begin
                if (ob_level != 2'd2)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath
    always_comb
    begin
        wall_we      = 1'b0;
        dist_we      = 1'b0;
        mem_waddr    = req_addr;
        mem_raddr    = req_addr;
        wall_wdata   = req.wall_bit;
        dist_wdata   = UNREACHED;
        q_clear      = 1'b0;
        q_push       = 1'b0;
        q_push_data  = nb_addr_reg;
        q_pop        = 1'b0;
        sweep_next   = sweep_reg;
        here_next    = here_reg;
        value_next   = value_reg;
        k_next       = k_reg;
        nb_addr_next = nb_addr_reg;
        nb_in_next   = nb_in_reg;
        case (state_reg)
            ST_BOOT:
            begin
                wall_we    = 1'b1;
                dist_we    = 1'b1;
                mem_waddr  = sweep_reg;
                wall_wdata = 1'b0;
                sweep_next = sweep_reg + 1'b1;
            end
            ST_IDLE:
            begin
                wall_we = req_fire && (req.operation == OP_WRITE_WALL) && req_in;
                q_clear = req_fire && (req.operation == OP_COMPUTE);
            end
            ST_CLEAR:
            begin
                dist_we    = 1'b1;
                mem_waddr  = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
            end
            ST_SEED:
            begin
                dist_we     = src_in_reg;
                mem_waddr   = src_addr_reg;
                dist_wdata  = 8'd0;
                q_push      = src_in_reg;
                q_push_data = src_addr_reg;
            end
            ST_POP:
            begin
                q_pop = !q_empty;
            end
            ST_HERE:
            begin
                mem_raddr = q_head;
                here_next = q_head;
            end
            ST_VALUE:
            begin
                value_next   = dist_q;
                mem_raddr    = nb_addr_calc;
                nb_addr_next = nb_addr_calc;
                nb_in_next   = nb_in_calc;
                k_next       = 3'd0;
            end
            ST_NEIGHBOR:
            begin
                // check neighbor k while the read of neighbor k+1 is in flight
                dist_we      = grow;
                mem_waddr    = nb_addr_reg;
                dist_wdata   = value_reg + 8'd1;
                q_push       = grow;
                mem_raddr    = nb_addr_calc;
                nb_addr_next = nb_addr_calc;
                nb_in_next   = nb_in_calc;
                k_next       = k_reg + 3'd1;
            end
            default:
            begin
            end
        endcase
    end

    // result of the item accepted in the previous cycle, or of a finished walk
    always_comb
    begin
        ob_push               = 1'b0;
        ob_item.distance      = 8'd0;
        ob_item.cell_is_wall  = held_wall_reg;
        if (pend_reg && (pend_op_reg != OP_COMPUTE))
        begin
            ob_push = 1'b1;
            if (pend_op_reg == OP_READ)
            begin
                ob_item.distance = pend_in_reg ? dist_q : UNREACHED;
            end
            if (!pend_in_reg)
            begin
                ob_item.cell_is_wall = 1'b1;
            end
            else if (pend_op_reg == OP_WRITE_WALL)
            begin
                ob_item.cell_is_wall = pend_wb_reg;
            end
            else
            begin
                ob_item.cell_is_wall = wall_q;
            end
        end
        else if ((state_reg == ST_DONE) && (ob_level != 2'd2))
        begin
            ob_push = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_BOOT;
            sweep_reg <= '0;
            k_reg     <= 3'd0;
            pend_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            sweep_reg <= sweep_next;
            k_reg     <= k_next;
            pend_reg  <= req_fire;
        end
    end

    always_ff @(posedge clk)
    begin
        here_reg    <= here_next;
        value_reg   <= value_next;
        nb_addr_reg <= nb_addr_next;
        nb_in_reg   <= nb_in_next;
        if (req_fire)
        begin
            pend_op_reg  <= req.operation;
            pend_in_reg  <= req_in;
            pend_wb_reg  <= req.wall_bit;
            src_addr_reg <= req_addr;
            src_in_reg   <= req_in;
        end
        if (pend_reg && (pend_op_reg == OP_COMPUTE))
        begin
            held_wall_reg <= pend_in_reg ? wall_q : 1'b1;
        end
    end

    gbdf_cell_store #(
        .AW (AW)
    ) u_cell_store (
        .clk        (clk),
        .wall_we    (wall_we),
        .dist_we    (dist_we),
        .waddr      (mem_waddr),
        .wall_wdata (wall_wdata),
        .dist_wdata (dist_wdata),
        .raddr      (mem_raddr),
        .wall_rdata (wall_q),
        .dist_rdata (dist_q)
    );

    gbdf_queue #(
        .AW (AW)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .clear     (q_clear),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .head_data (q_head),
        .empty     (q_empty)
    );

    gbdf_out_buf u_out_buf (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (ob_push),
        .push_item (ob_item),
        .valid     (rsp_valid),
        .ready     (rsp_ready),
        .item      (rsp),
        .level     (ob_level)
    );

`ifndef SYNTHESIS
    a_ready_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req_ready |-> (state_reg == ST_IDLE))
        else $error("item accepted outside idle");

    a_pend_from_accept: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg |-> $past(req_valid && req_ready))
        else $error("pending result without an accepted item");

    a_grow_queues: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_NEIGHBOR) |-> (dist_we == q_push))
        else $error("distance update and queue push out of step");

    a_done_hands_over: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (ob_level != 2'd2)) |-> ob_push)
        else $error("walk finished without a result");
`endif

endmodule
`default_nettype wire

>>> rtl/gbdf_cell_store.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbdf_cell_store
// Wall bitmap and distance map, one entry per cell, registered reads.
// ----------------------------------------------------------------------------
module gbdf_cell_store #(
    parameter int AW = 12
) (
    input  wire logic          clk,
    input  wire logic          wall_we,
    input  wire logic          dist_we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic          wall_wdata,
    input  wire logic [7:0]    dist_wdata,
    input  wire logic [AW-1:0] raddr,
    output logic               wall_rdata,
    output logic [7:0]         dist_rdata
);

    logic       wall_mem [0:(1<<AW)-1];
    logic [7:0] dist_mem [0:(1<<AW)-1];

    always_ff @(posedge clk)
    begin
        if (wall_we)
        begin
            wall_mem[waddr] <= wall_wdata;
        end
        wall_rdata <= wall_mem[raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dist_we)
        begin
            dist_mem[waddr] <= dist_wdata;
        end
        dist_rdata <= dist_mem[raddr];
    end

endmodule
`default_nettype wire

>>> rtl/gbdf_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbdf_queue
// Visit queue of cell addresses for the breadth-first walk, one memory.
// ----------------------------------------------------------------------------
module gbdf_queue #(
    parameter int AW = 12
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          clear,
    input  wire logic          push,
    input  wire logic [AW-1:0] push_data,
    input  wire logic          pop,
    output logic [AW-1:0]      head_data,
    output logic               empty
);

    localparam logic [AW:0] DEPTH = {1'b1, {AW{1'b0}}};

    logic [AW-1:0] q_mem [0:(1<<AW)-1];
    logic [AW:0]   head_reg;
    logic [AW:0]   head_next;
    logic [AW:0]   tail_reg;
    logic [AW:0]   tail_next;

    assign empty = (head_reg == tail_reg);

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        if (clear)
        begin
            head_next = '0;
            tail_next = '0;
        end
        else
        begin
            if (pop)
            begin
                head_next = head_reg + 1'b1;
            end
            if (push)
            begin
                tail_next = tail_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
        end
    end

    // data of the head entry shows up the cycle after it is popped
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[tail_reg[AW-1:0]] <= push_data;
        end
        head_data <= q_mem[head_reg[AW-1:0]];
    end

`ifndef SYNTHESIS
    a_pop_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue popped while empty");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> ((tail_reg - head_reg) != DEPTH))
        else $error("queue pushed while full");

    a_clear_empties: assert property (@(posedge clk) disable iff (!rst_n)
        clear |=> empty)
        else $error("queue not empty after clear");
`endif

endmodule
`default_nettype wire

>>> rtl/gbdf_out_buf.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gbdf_out_buf
// Two-entry result buffer between the core and the response channel.
// ----------------------------------------------------------------------------
module gbdf_out_buf
    import gbdf_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      push,
    input  wire rsp_item_t push_item,
    output logic           valid,
    input  wire logic      ready,
    output rsp_item_t      item,
    output logic [1:0]     level
);

    rsp_item_t  slot_reg [0:1];
    logic       wr_ptr_reg;
    logic       wr_ptr_next;
    logic       rd_ptr_reg;
    logic       rd_ptr_next;
    logic [1:0] level_reg;
    logic [1:0] level_next;
    logic       pop;

    assign valid = (level_reg != 2'd0);
    assign item  = slot_reg[rd_ptr_reg];
    assign level = level_reg;
    assign pop   = valid && ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        level_next  = level_reg;
        if (push && !pop)
        begin
            level_next = level_reg + 2'd1;
        end
        else if (pop && !push)
        begin
            level_next = level_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            level_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            level_reg  <= level_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

>>> tb/sv/grid_bfs_distance_field_checker.sv
// ----------------------------------------------------------------------------
// grid_bfs_distance_field_checker
// Passive checker for the grid distance field core. It follows register
// writes and accepted request items, keeps its own wall and distance maps,
// floods the distance map breadth first on compute items and compares each
// accepted result, field by field, with the oldest open prediction.
// ----------------------------------------------------------------------------
module grid_bfs_distance_field_checker
    import gbdf_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   req_valid,
    input  wire logic                   req_ready,
    input  wire req_item_t              req,
    input  wire logic                   rsp_valid,
    input  wire logic                   rsp_ready,
    input  wire rsp_item_t              rsp,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output int                          mismatches,
    output int                          outstanding,
    output int                          checked
);

    localparam int GRID_W     = DEF_MAX_WIDTH;
    localparam int GRID_H     = DEF_MAX_HEIGHT;
    localparam int CELLS      = GRID_W * GRID_H;
    localparam int REPORT_CAP = 40;

    bit         wall_bits  [CELLS];
    logic [7:0] step_count [CELLS];
    int         frontier   [CELLS];
    logic [7:0] radius;
    logic [6:0] cols;
    logic [6:0] rows;
    rsp_item_t  pending_results [$];

    function automatic bit on_grid(input int x, input int y);
        int used_cols;
        int used_rows;
        used_cols = (int'(cols) < GRID_W) ? int'(cols) : GRID_W;
        used_rows = (int'(rows) < GRID_H) ? int'(rows) : GRID_H;
        return (x >= 0) && (y >= 0) && (x < used_cols) && (y < used_rows);
    endfunction

    // shortest step counts; only cells below the radius pass the walk on
    function automatic void flood_distances(input int sx, input int sy);
        int i;
        int head;
        int tail;
        int here;
        int level;
        int dx;
        int dy;
        int nx;
        int ny;
        int n;
        for (i = 0; i < CELLS; i++)
            step_count[i] = UNREACHED;
        if (!on_grid(sx, sy))
            return;
        step_count[sy * GRID_W + sx] = 8'd0;
        frontier[0] = sy * GRID_W + sx;
        head = 0;
        tail = 1;
        while (head < tail)
        begin
            here = frontier[head];
            head++;
            level = int'(step_count[here]);
            if (level < int'(radius))
            begin
                for (dy = -1; dy <= 1; dy++)
                begin
                    for (dx = -1; dx <= 1; dx++)
                    begin
                        nx = here % GRID_W + dx;
                        ny = here / GRID_W + dy;
                        n  = ny * GRID_W + nx;
                        if ((dx != 0 || dy != 0) && on_grid(nx, ny) && !wall_bits[n]
                            && int'(step_count[n]) > level + 1)
                        begin
                            step_count[n] = 8'(level + 1);
                            frontier[tail] = n;
                            tail++;
                        end
                    end
                end
            end
        end
    endfunction

    function automatic rsp_item_t result_of_item(input req_item_t item);
        rsp_item_t res;
        bit        in_grid;
        int        idx;
        in_grid = on_grid(int'(item.cell_x), int'(item.cell_y));
        idx = int'(item.cell_y) * GRID_W + int'(item.cell_x);
        res.distance = 8'd0;
        case (item.operation)
            OP_WRITE_WALL:
                if (in_grid)
                    wall_bits[idx] = item.wall_bit;
            OP_COMPUTE:
                flood_distances(int'(item.cell_x), int'(item.cell_y));
            OP_READ:
                res.distance = in_grid ? step_count[idx] : UNREACHED;
            default:
                ;
        endcase
        // cells off the grid in use read as walls
        res.cell_is_wall = in_grid ? wall_bits[idx] : 1'b1;
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch_ports
        rsp_item_t want;
        int        i;
        if (!rst_n)
        begin
            for (i = 0; i < CELLS; i++)
            begin
                wall_bits[i]  = 1'b0;
                step_count[i] = UNREACHED;
            end
            radius = RADIUS_RESET;
            cols   = MAP_SIZE_RESET;
            rows   = MAP_SIZE_RESET;
            pending_results.delete();
            mismatches  = 0;
            outstanding = 0;
            checked     = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SINK_RADIUS: radius = cfg_data;
                    REG_MAP_WIDTH:   cols   = cfg_data[6:0];
                    REG_MAP_HEIGHT:  rows   = cfg_data[6:0];
                    default:         ;
                endcase
            end
            if (req_valid && req_ready)
                pending_results.push_back(result_of_item(req));
            if (rsp_valid && rsp_ready)
            begin
                if (pending_results.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP)
                        $error("result with no open item: distance %0d cell_is_wall %0b",
                               rsp.distance, rsp.cell_is_wall);
                end
                else
                begin
                    want = pending_results.pop_front();
                    checked++;
                    if (rsp.distance !== want.distance)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_CAP)
                            $error("distance: expected %0d, got %0d",
                                   want.distance, rsp.distance);
                    end
                    if (rsp.cell_is_wall !== want.cell_is_wall)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_CAP)
                            $error("cell_is_wall: expected %0b, got %0b",
                                   want.cell_is_wall, rsp.cell_is_wall);
                    end
                end
            end
            outstanding = pending_results.size();
        end
    end

endmodule

>>> tb/sv/grid_bfs_distance_field_core_test.sv
// ----------------------------------------------------------------------------
// grid_bfs_distance_field_core_test
// Drives wall writes, flood computes and distance reads into the distance
// field core under a range of radius and map size settings, with random
// stalls on both channels, and reports the verdict of the checker.
// ----------------------------------------------------------------------------
module grid_bfs_distance_field_core_test;
    import gbdf_pkg::*;

    localparam logic [1:0] OP_UNUSED   = 2'd3;
    localparam int         STUCK_LIMIT = 200000;
    localparam int         SETTLE      = 64;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   req_valid = 1'b0;
    logic                   req_ready;
    req_item_t              req       = '0;
    logic                   rsp_valid;
    logic                   rsp_ready = 1'b0;
    rsp_item_t              rsp;
    logic                   cfg_we    = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = REG_SINK_RADIUS;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    int         mismatches;
    int         outstanding;
    int         checked;
    bit         calm         = 1'b0;
    int         stall_left   = 0;
    int         stuck_cycles = 0;
    int         n_writes     = 0;
    int         n_computes   = 0;
    int         n_reads      = 0;
    int         n_unused     = 0;
    int         n_settings   = 1;
    logic [6:0] cur_cols     = MAP_SIZE_RESET;
    logic [6:0] cur_rows     = MAP_SIZE_RESET;

    grid_bfs_distance_field_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    grid_bfs_distance_field_checker flood_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_valid   (req_valid),
        .req_ready   (req_ready),
        .req         (req),
        .rsp_valid   (rsp_valid),
        .rsp_ready   (rsp_ready),
        .rsp         (rsp),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .checked     (checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // result side back-pressure in bursts
    always @(negedge clk)
    begin
        if (calm)
            rsp_ready <= 1'b1;
        else if (stall_left > 0)
        begin
            stall_left--;
            rsp_ready <= 1'b0;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            stall_left = int'($urandom_range(1, 6)) - 1;
            rsp_ready <= 1'b0;
        end
        else
            rsp_ready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == STUCK_LIMIT)
        begin
            $display("watchdog: no item moved for %0d cycles", STUCK_LIMIT);
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic req_item_t cell_item(input logic [1:0] op, input int x, input int y,
                                            input bit wb);
        req_item_t item;
        item.operation = op;
        item.cell_x    = 6'(x);
        item.cell_y    = 6'(y);
        item.wall_bit  = wb;
        return item;
    endfunction

    function automatic req_item_t random_item(input int used_cols, input int used_rows);
        req_item_t item;
        int        pick;
        pick = int'($urandom_range(0, 99));
        if (pick < 36)
            item.operation = OP_WRITE_WALL;
        else if (pick < 42)
            item.operation = OP_COMPUTE;
        else if (pick < 98)
            item.operation = OP_READ;
        else
            item.operation = OP_UNUSED;
        // mostly cells on the grid in use, some anywhere
        if ($urandom_range(0, 6) == 0)
        begin
            item.cell_x = 6'($urandom_range(0, 63));
            item.cell_y = 6'($urandom_range(0, 63));
        end
        else
        begin
            item.cell_x = 6'($urandom_range(0, used_cols - 1));
            item.cell_y = 6'($urandom_range(0, used_rows - 1));
        end
        item.wall_bit = ($urandom_range(0, 2) == 0);
        return item;
    endfunction

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input req_item_t item);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = int'($urandom_range(1, 6));
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req       <= item;
        req_valid <= 1'b1;
        do
            @(posedge clk);
        while (!req_ready);
        case (item.operation)
            OP_WRITE_WALL: n_writes++;
            OP_COMPUTE:    n_computes++;
            OP_READ:       n_reads++;
            default:       n_unused++;
        endcase
        @(negedge clk);
    endtask

    task automatic drain_results();
        req_valid <= 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // registers change only with nothing in flight
    task automatic apply_settings(input logic [7:0] radius, input logic [6:0] cols,
                                  input logic [6:0] rows);
        drain_results();
        cfg_we    <= 1'b1;
        cfg_index <= REG_SINK_RADIUS;
        cfg_data  <= radius;
        @(negedge clk);
        cfg_index <= REG_MAP_WIDTH;
        cfg_data  <= {1'b0, cols};
        @(negedge clk);
        cfg_index <= REG_MAP_HEIGHT;
        cfg_data  <= {1'b0, rows};
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
        cur_cols = cols;
        cur_rows = rows;
        n_settings++;
    endtask

    task automatic random_block(input int n_items);
        int k;
        int used_cols;
        int used_rows;
        used_cols = (int'(cur_cols) > DEF_MAX_WIDTH) ? DEF_MAX_WIDTH : int'(cur_cols);
        used_rows = (int'(cur_rows) > DEF_MAX_HEIGHT) ? DEF_MAX_HEIGHT : int'(cur_rows);
        for (k = 0; k < n_items; k++)
            send_item(random_item(used_cols, used_rows));
    endtask

    initial
    begin
        int         blk;
        logic [7:0] radius;
        logic [6:0] cols;
        logic [6:0] rows;

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings: full grid, radius 25
        send_item(cell_item(OP_READ, 0, 0, 1'b0));
        send_item(cell_item(OP_WRITE_WALL, 32, 32, 1'b1));
        send_item(cell_item(OP_WRITE_WALL, 5, 5, 1'b1));
        send_item(cell_item(OP_WRITE_WALL, 5, 5, 1'b0));
        send_item(cell_item(OP_WRITE_WALL, 33, 32, 1'b1));
        // source sits on a wall
        send_item(cell_item(OP_COMPUTE, 32, 32, 1'b0));
        send_item(cell_item(OP_READ, 32, 32, 1'b0));
        send_item(cell_item(OP_READ, 33, 33, 1'b0));
        send_item(cell_item(OP_READ, 57, 32, 1'b0));
        send_item(cell_item(OP_READ, 58, 32, 1'b0));
        send_item(cell_item(OP_READ, 33, 32, 1'b0));
        send_item(cell_item(OP_UNUSED, 32, 32, 1'b1));
        send_item(cell_item(OP_COMPUTE, 63, 63, 1'b0));
        send_item(cell_item(OP_READ, 0, 0, 1'b0));

        // zero radius: only the source is reached
        apply_settings(8'd0, 7'd64, 7'd64);
        send_item(cell_item(OP_COMPUTE, 10, 10, 1'b0));
        send_item(cell_item(OP_READ, 11, 10, 1'b0));

        apply_settings(8'd255, 7'd64, 7'd64);
        send_item(cell_item(OP_COMPUTE, 0, 63, 1'b0));
        send_item(cell_item(OP_READ, 63, 0, 1'b0));

        // oversized width clamps, zero height leaves no grid at all
        apply_settings(8'd254, 7'd127, 7'd0);
        send_item(cell_item(OP_WRITE_WALL, 3, 3, 1'b1));
        send_item(cell_item(OP_COMPUTE, 3, 3, 1'b0));
        send_item(cell_item(OP_READ, 3, 3, 1'b0));

        apply_settings(8'd254, 7'd1, 7'd1);
        send_item(cell_item(OP_COMPUTE, 0, 0, 1'b0));
        send_item(cell_item(OP_READ, 0, 0, 1'b0));
        send_item(cell_item(OP_READ, 1, 0, 1'b0));

        for (blk = 0; blk < 10; blk++)
        begin
            if (blk == 0 || $urandom_range(0, 4) == 0)
            begin
                // full grid, small radius keeps each flood short
                cols   = 7'd64;
                rows   = 7'd64;
                radius = 8'($urandom_range(0, 12));
            end
            else if (blk == 1)
            begin
                cols   = 7'($urandom_range(15, 63));
                rows   = 7'($urandom_range(1, 4));
                radius = 8'($urandom_range(0, 254));
            end
            else
            begin
                cols   = 7'($urandom_range(1, 14));
                rows   = 7'($urandom_range(1, 14));
                radius = $urandom_range(0, 1) ? 8'($urandom_range(0, 6))
                                              : 8'($urandom_range(7, 254));
            end
            apply_settings(radius, cols, rows);
            random_block(100);
        end

        // closing stretch runs with both sides always ready
        apply_settings(8'($urandom_range(1, 30)), 7'($urandom_range(8, 24)),
                       7'($urandom_range(8, 24)));
        calm = 1'b1;
        random_block(100);

        drain_results();
        repeat (SETTLE) @(negedge clk);

        $display("covered %0d wall writes, %0d floods, %0d reads, %0d unused codes",
                 n_writes, n_computes, n_reads, n_unused);
        $display("over %0d radius and grid settings; %0d results compared",
                 n_settings, checked);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

>>> grid_bfs_distance_field_core.f
rtl/gbdf_pkg.sv
rtl/gbdf_cell_store.sv
rtl/gbdf_queue.sv
rtl/gbdf_out_buf.sv
rtl/grid_bfs_distance_field_core.sv
tb/sv/grid_bfs_distance_field_checker.sv
tb/sv/grid_bfs_distance_field_core_test.sv
